### sv/lbwp_pkg.sv
// ----------------------------------------------------------------------------
// lbwp_pkg
// Shared types and constants of the load balanced worker picker.
// ----------------------------------------------------------------------------
package lbwp_pkg;

   localparam int unsigned LOAD_W   = 32;
   localparam int unsigned WEIGHT_W = 16;
   localparam int unsigned KIND_W   = 4;
   localparam int unsigned REF_W    = 16;
   localparam int unsigned RND_W    = 16;
   localparam int unsigned CHOSEN_W = 3;

   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   // Eligible when load <= (ElgNum/ElgDen) * average load.
   localparam int unsigned ELG_NUM = 4;
   localparam int unsigned ELG_DEN = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELIG,
      ST_MED,
      ST_KMUL,
      ST_SCAN,
      ST_UPD_RD,
      ST_UPD_WR
   } lbwp_state_type;

endpackage

### sv/lbwp_req_if.sv
// ----------------------------------------------------------------------------
// lbwp_req_if
// Dispatch request channel: valid/ready handshake with the task fields.
// ----------------------------------------------------------------------------
interface lbwp_req_if
   import lbwp_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] load_weight;
   logic [KIND_W-1:0]   task_kind;
   logic [REF_W-1:0]    task_ref;
   logic [RND_W-1:0]    random_value;

   modport source (output valid, load_weight, task_kind, task_ref, random_value,
                   input ready);
   modport sink   (input valid, load_weight, task_kind, task_ref, random_value,
                   output ready);
endinterface

### sv/lbwp_rsp_if.sv
// ----------------------------------------------------------------------------
// lbwp_rsp_if
// Dispatch result channel: valid/ready handshake with the chosen worker.
// ----------------------------------------------------------------------------
interface lbwp_rsp_if
   import lbwp_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [CHOSEN_W-1:0] chosen_worker;
   logic [KIND_W-1:0]   task_kind_out;
   logic [REF_W-1:0]    task_ref_out;

   modport source (output valid, chosen_worker, task_kind_out, task_ref_out,
                   input ready);
   modport sink   (input valid, chosen_worker, task_kind_out, task_ref_out,
                   output ready);
endinterface

### sv/lbwp_load_mem.sv
// ----------------------------------------------------------------------------
// lbwp_load_mem
// Per-worker load counters: one write port, two registered read ports.
// Entries not yet written read as zero through a per-entry valid bit.
// ----------------------------------------------------------------------------
module lbwp_load_mem
   import lbwp_pkg::*;
#(
   parameter int unsigned WORKERS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(WORKERS)-1:0] rd_a_addr,
   input  logic [$clog2(WORKERS)-1:0] rd_b_addr,
   output logic [LOAD_W-1:0]          rd_a_data,
   output logic [LOAD_W-1:0]          rd_b_data,
   input  logic                       wr_en,
   input  logic [$clog2(WORKERS)-1:0] wr_addr,
   input  logic [LOAD_W-1:0]          wr_data
);
   logic [LOAD_W-1:0]  mem [WORKERS];
   logic [WORKERS-1:0] valid_ff;
   logic [LOAD_W-1:0]  rd_a_raw_ff;
   logic [LOAD_W-1:0]  rd_b_raw_ff;
   logic               rd_a_vld_ff;
   logic               rd_b_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_raw_ff <= mem[rd_a_addr];
      rd_b_raw_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_a_vld_ff <= 1'b0;
         rd_b_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_a_vld_ff <= valid_ff[rd_a_addr];
         rd_b_vld_ff <= valid_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_vld_ff ? rd_a_raw_ff : '0;
   assign rd_b_data = rd_b_vld_ff ? rd_b_raw_ff : '0;

endmodule

### sv/lbwp_ctrl.sv
// ----------------------------------------------------------------------------
// lbwp_ctrl
// Sequencer: sweeps the load memory for the average test, falls back to a
// rank sweep against the upper median, picks the k-th eligible worker and
// writes back the saturated load.
// ----------------------------------------------------------------------------
module lbwp_ctrl
   import lbwp_pkg::*;
#(
   parameter int unsigned WORKERS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [WEIGHT_W-1:0]        weight,
   input  logic [RND_W-1:0]           rnd,
   input  logic                       out_free,
   output logic                       idle,
   output logic                       done,
   output logic [$clog2(WORKERS)-1:0] pick,
   output logic [$clog2(WORKERS)-1:0] rd_a_addr,
   output logic [$clog2(WORKERS)-1:0] rd_b_addr,
   input  logic [LOAD_W-1:0]          rd_a_data,
   input  logic [LOAD_W-1:0]          rd_b_data,
   output logic                       wr_en,
   output logic [$clog2(WORKERS)-1:0] wr_addr,
   output logic [LOAD_W-1:0]          wr_data
);
   localparam int unsigned IDX_W = $clog2(WORKERS);
   localparam int unsigned CNT_W = $clog2(WORKERS + 1);
   localparam int unsigned SUM_W = LOAD_W + $clog2(WORKERS);
   localparam int unsigned CMP_W = SUM_W + 3;
   localparam int unsigned SCALE = ELG_DEN * WORKERS;
   localparam int unsigned PRD_W = RND_W + CNT_W;

   localparam logic [IDX_W:0]   LAST_CNT = (IDX_W + 1)'(WORKERS);
   localparam logic [IDX_W:0]   LAST_IDX = (IDX_W + 1)'(WORKERS - 1);
   localparam logic [CNT_W-1:0] HALF     = CNT_W'(WORKERS / 2);

   lbwp_state_type state_ff, state_in;

   logic [IDX_W:0]     a_ff;
   logic [IDX_W:0]     b_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   less_ff;
   logic [CNT_W-1:0]   seen_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [WORKERS-1:0] elig_ff;
   logic [IDX_W-1:0]   pick_ff;
   logic [SUM_W-1:0]   sum_ff;

   logic [IDX_W:0]     prev_cnt;
   logic [IDX_W-1:0]   prev_idx;
   logic [IDX_W-1:0]   scan_idx;
   logic [CMP_W-1:0]   lhs;
   logic [CMP_W-1:0]   rhs;
   logic               hit;
   logic [CNT_W-1:0]   count_nxt;
   logic               is_less;
   logic [CNT_W-1:0]   less_tot;
   logic [PRD_W-1:0]   prod;
   logic               found;
   logic [LOAD_W:0]    add_full;
   logic [LOAD_W-1:0]  new_load;
   logic [LOAD_W-1:0]  delta;

   // datapath terms
   always_comb begin
      prev_cnt  = a_ff - 1'b1;
      prev_idx  = prev_cnt[IDX_W-1:0];
      scan_idx  = a_ff[IDX_W-1:0];
      lhs       = CMP_W'(rd_a_data) * CMP_W'(SCALE);
      rhs       = CMP_W'(sum_ff) * CMP_W'(ELG_NUM);
      hit       = (a_ff != '0) && (lhs <= rhs);
      count_nxt = count_ff + CNT_W'(hit);
      is_less   = rd_b_data < rd_a_data;
      less_tot  = less_ff + CNT_W'(is_less);
      prod      = PRD_W'(rnd) * PRD_W'(count_ff);
      found     = elig_ff[scan_idx] && (seen_ff == k_ff);
      add_full  = {1'b0, rd_a_data} + (LOAD_W + 1)'(weight);
      new_load  = add_full[LOAD_W] ? LOAD_MAX : add_full[LOAD_W-1:0];
      delta     = new_load - rd_a_data;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_ELIG;
         end
         ST_ELIG: begin
            if (a_ff == LAST_CNT) begin
               state_in = (count_nxt == '0) ? ST_MED : ST_KMUL;
            end
         end
         ST_MED: begin
            if (b_ff == LAST_CNT && a_ff == LAST_IDX) state_in = ST_KMUL;
         end
         ST_KMUL: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (found) state_in = ST_UPD_RD;
         end
         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      idle      = 1'b0;
      done      = 1'b0;
      wr_en     = 1'b0;
      rd_a_addr = a_ff[IDX_W-1:0];
      rd_b_addr = b_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
         end
         ST_UPD_RD: begin
            rd_a_addr = pick_ff;
         end
         ST_UPD_WR: begin
            rd_a_addr = pick_ff;
            wr_en     = out_free;
            done      = out_free;
         end
         default: begin
         end
      endcase
   end

   assign pick    = pick_ff;
   assign wr_addr = pick_ff;
   assign wr_data = new_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff   <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         count_ff <= '0;
         less_ff  <= '0;
         seen_ff  <= '0;
         k_ff     <= '0;
         elig_ff  <= '0;
         pick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               a_ff     <= '0;
               b_ff     <= '0;
               count_ff <= '0;
               less_ff  <= '0;
               seen_ff  <= '0;
               elig_ff  <= '0;
            end
            ST_ELIG: begin
               // read data is registered, so it belongs to the previous address
               if (a_ff != '0) begin
                  elig_ff[prev_idx] <= hit;
                  count_ff          <= count_nxt;
               end
               a_ff <= (a_ff == LAST_CNT) ? '0 : a_ff + 1'b1;
            end
            ST_MED: begin
               if (b_ff == LAST_CNT) begin
                  // rank of this worker decides against the upper median
                  if (less_tot <= HALF) begin
                     elig_ff[scan_idx] <= 1'b1;
                     count_ff          <= count_ff + 1'b1;
                  end
                  less_ff <= '0;
                  b_ff    <= '0;
                  a_ff    <= (a_ff == LAST_IDX) ? '0 : a_ff + 1'b1;
               end else begin
                  if (b_ff != '0) less_ff <= less_tot;
                  b_ff <= b_ff + 1'b1;
               end
            end
            ST_KMUL: begin
               k_ff <= prod[PRD_W-1:RND_W];
            end
            ST_SCAN: begin
               if (found) begin
                  pick_ff <= scan_idx;
               end else begin
                  if (elig_ff[scan_idx]) seen_ff <= seen_ff + 1'b1;
                  a_ff <= a_ff + 1'b1;
               end
            end
            ST_UPD_WR: begin
               if (out_free) sum_ff <= sum_ff + SUM_W'(delta);
            end
            default: begin
            end
         endcase
      end
   end

endmodule

### sv/load_balanced_worker_picker_top.sv
// ----------------------------------------------------------------------------
// load_balanced_worker_picker_top
// Assigns each dispatch request to a worker by accumulated load.
// ----------------------------------------------------------------------------
// Each request runs from acceptance to result through the average test, and
// through the median fallback as well when no worker is at most 0.8 times the
// average load; the pick scan runs only as far as the chosen worker. The steps
// are sweeps over the single load memory: one pass for the average test, one
// rank pass per worker over the second read port for the fallback, a step for
// the pick rank, a scan for the pick, and a read and a write-back of the chosen
// counter. The write-back waits while the output register is still full, and
// the next request is taken in the idle cycle after it.
// A running sum of all loads is kept in a register. A new request is taken
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module load_balanced_worker_picker_top
   import lbwp_pkg::*;
#(
   parameter int unsigned WORKERS = 8
) (
   input  logic     clock,
   input  logic     reset,
   lbwp_req_if.sink   req_ch,
   lbwp_rsp_if.source rsp_ch
);
   localparam int unsigned IDX_W = $clog2(WORKERS);

   logic [WEIGHT_W-1:0] weight_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [REF_W-1:0]    ref_ff;
   logic [RND_W-1:0]    rnd_ff;

   logic                rsp_valid_ff;
   logic [CHOSEN_W-1:0] chosen_ff;
   logic [KIND_W-1:0]   kind_out_ff;
   logic [REF_W-1:0]    ref_out_ff;

   logic                start;
   logic                idle;
   logic                done;
   logic                out_free;
   logic [IDX_W-1:0]    pick;
   logic [IDX_W+2:0]    pick_ext;
   logic [IDX_W-1:0]    rd_a_addr;
   logic [IDX_W-1:0]    rd_b_addr;
   logic [LOAD_W-1:0]   rd_a_data;
   logic [LOAD_W-1:0]   rd_b_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [LOAD_W-1:0]   wr_data;

   assign req_ch.ready = idle;
   assign start        = req_ch.valid && idle;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign pick_ext     = {3'b000, pick};

   // hold the request fields for the whole item
   always_ff @(posedge clock) begin
      if (start) begin
         weight_ff <= req_ch.load_weight;
         kind_ff   <= req_ch.task_kind;
         ref_ff    <= req_ch.task_ref;
         rnd_ff    <= req_ch.random_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         chosen_ff   <= pick_ext[CHOSEN_W-1:0];
         kind_out_ff <= kind_ff;
         ref_out_ff  <= ref_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.chosen_worker = chosen_ff;
   assign rsp_ch.task_kind_out = kind_out_ff;
   assign rsp_ch.task_ref_out  = ref_out_ff;

   lbwp_ctrl #(
      .WORKERS (WORKERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .weight    (weight_ff),
      .rnd       (rnd_ff),
      .out_free  (out_free),
      .idle      (idle),
      .done      (done),
      .pick      (pick),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   lbwp_load_mem #(
      .WORKERS (WORKERS)
   ) u_load_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

endmodule

### tb/tb_load_balanced_worker_picker_top.sv
// ----------------------------------------------------------------------------
// tb_load_balanced_worker_picker_top
// Self-checking bench for the load balanced worker picker. Dispatch requests
// are fed from a queue by a clocked driver. A local load table predicts the
// chosen worker for every accepted request. A clocked monitor checks each
// result against the oldest prediction, with random stalls on both sides and
// one long output hold-off.
// ----------------------------------------------------------------------------
module tb_load_balanced_worker_picker_top
   import lbwp_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_WORKERS  = 8;
   localparam int unsigned AVG_NUM      = 4;    // eligible at 4/5 of the average
   localparam int unsigned AVG_DEN      = 5;
   localparam int unsigned RANDOM_ITEMS = 1234;
   localparam int unsigned CALM_FIRST   = 300;  // no idling on either side here
   localparam int unsigned CALM_LAST    = 550;
   localparam int unsigned HOLD_AT      = 150;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 120;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct packed {
      logic [WEIGHT_W-1:0] load_weight;
      logic [KIND_W-1:0]   task_kind;
      logic [REF_W-1:0]    task_ref;
      logic [RND_W-1:0]    random_value;
   } dispatch_req_type;

   typedef struct packed {
      logic [CHOSEN_W-1:0] chosen_worker;
      logic [KIND_W-1:0]   task_kind;
      logic [REF_W-1:0]    task_ref;
   } dispatch_rsp_type;

   logic clock;
   logic reset;

   lbwp_req_if req_bus ();
   lbwp_rsp_if rsp_bus ();

   load_balanced_worker_picker_top #(
      .WORKERS (NUM_WORKERS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   dispatch_req_type  pending_req[$];
   dispatch_rsp_type  expected_pick[$];
   dispatch_req_type  offered_req;
   dispatch_rsp_type  seen_rsp;
   dispatch_rsp_type  wanted_rsp;
   logic [LOAD_W-1:0] worker_load_model [NUM_WORKERS];
   int unsigned       total_requests;
   int unsigned       requests_taken;
   int unsigned       mismatches;
   logic              hold_rsp;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic in_calm_window();
      return requests_taken >= CALM_FIRST && requests_taken < CALM_LAST;
   endfunction

   // Choose a worker for one request and charge its weight to the load table.
   function automatic dispatch_rsp_type assign_worker(input dispatch_req_type req);
      logic [LOAD_W-1:0]      ranked [NUM_WORKERS];
      logic [LOAD_W-1:0]      swap;
      logic [LOAD_W-1:0]      median;
      logic [NUM_WORKERS-1:0] eligible;
      logic [63:0]            total;
      logic [63:0]            scaled;
      logic [LOAD_W:0]        grown;
      int unsigned            count;
      int unsigned            slot;
      int unsigned            seen;
      int unsigned            chosen;
      dispatch_rsp_type       rsp;

      total = '0;
      foreach (worker_load_model[i]) total += 64'(worker_load_model[i]);
      count = 0;
      foreach (worker_load_model[i]) begin
         scaled = 64'(AVG_DEN * NUM_WORKERS) * 64'(worker_load_model[i]);
         eligible[i] = scaled <= 64'(AVG_NUM) * total;
         if (eligible[i]) count++;
      end

      // nobody under the average bound: fall back to the upper median
      if (count == 0) begin
         foreach (worker_load_model[i]) ranked[i] = worker_load_model[i];
         for (int i = 1; i < NUM_WORKERS; i++) begin
            for (int j = i; j > 0 && ranked[j-1] > ranked[j]; j--) begin
               swap        = ranked[j];
               ranked[j]   = ranked[j-1];
               ranked[j-1] = swap;
            end
         end
         median = ranked[NUM_WORKERS/2];
         foreach (worker_load_model[i]) begin
            eligible[i] = worker_load_model[i] <= median;
            if (eligible[i]) count++;
         end
      end

      slot   = int'((64'(req.random_value) * 64'(count)) >> RND_W);
      seen   = 0;
      chosen = 0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
         if (eligible[i]) begin
            if (seen == slot) begin
               chosen = i;
               break;
            end
            seen++;
         end
      end

      // saturate instead of wrapping
      grown = {1'b0, worker_load_model[chosen]} + (LOAD_W+1)'(req.load_weight);
      worker_load_model[chosen] = grown[LOAD_W] ? '1 : grown[LOAD_W-1:0];

      rsp.chosen_worker = chosen[CHOSEN_W-1:0];
      rsp.task_kind     = req.task_kind;
      rsp.task_ref      = req.task_ref;
      return rsp;
   endfunction

   task automatic queue_request(input logic [WEIGHT_W-1:0] weight,
                                input logic [KIND_W-1:0] kind,
                                input logic [REF_W-1:0] slot_ref,
                                input logic [RND_W-1:0] pick_rnd);
      dispatch_req_type req;
      req.load_weight  = weight;
      req.task_kind    = kind;
      req.task_ref     = slot_ref;
      req.random_value = pick_rnd;
      pending_req = {pending_req, req};
   endtask

   task automatic report_mismatch(input string what, input dispatch_rsp_type want,
                                  input dispatch_rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t dispatch mismatch (%s): expected worker %0d kind %0d ref %h,",
                  $time, what, want.chosen_worker, want.task_kind, want.task_ref);
         $display("    got worker %0d kind %0d ref %h",
                  got.chosen_worker, got.task_kind, got.task_ref);
      end
   endtask

   // Request driver: hold an offered item until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_pick = {expected_pick, assign_worker(offered_req)};
            requests_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_req.size() > 0 && (in_calm_window() || $urandom_range(99) >= 20)) begin
               offered_req = pending_req.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.load_weight  <= offered_req.load_weight;
               req_bus.task_kind    <= offered_req.task_kind;
               req_bus.task_ref     <= offered_req.task_ref;
               req_bus.random_value <= offered_req.random_value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.chosen_worker = rsp_bus.chosen_worker;
            seen_rsp.task_kind     = rsp_bus.task_kind_out;
            seen_rsp.task_ref      = rsp_bus.task_ref_out;
            if (expected_pick.size() == 0) begin
               report_mismatch("result with nothing pending", '0, seen_rsp);
            end else begin
               wanted_rsp = expected_pick.pop_front();
               if (seen_rsp.chosen_worker !== wanted_rsp.chosen_worker ||
                   seen_rsp.task_kind !== wanted_rsp.task_kind ||
                   seen_rsp.task_ref !== wanted_rsp.task_ref) begin
                  report_mismatch("wrong field", wanted_rsp, seen_rsp);
               end
            end
         end
         rsp_bus.ready <= !hold_rsp && (in_calm_window() || $urandom_range(99) >= 20);
      end
   end

   // Long output hold-off so the block fills up and backs up its input.
   initial begin
      hold_rsp = 1'b0;
      while (requests_taken < HOLD_AT) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      logic [WEIGHT_W-1:0] weight;
      logic [RND_W-1:0]    pick_rnd;
      int unsigned         mode;

      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.load_weight  = '0;
      req_bus.task_kind    = '0;
      req_bus.task_ref     = '0;
      req_bus.random_value = '0;
      rsp_bus.ready        = 1'b0;
      requests_taken       = 0;
      mismatches           = 0;
      foreach (worker_load_model[i]) worker_load_model[i] = '0;

      // all loads zero: first and last worker
      queue_request(16'h0000, 4'd0, 16'h0000, 16'h0000);
      queue_request(16'hFFFF, 4'd1, 16'hFFFF, 16'hFFFF);
      // fill the other workers with the same load
      for (int i = 2; i < 9; i++) queue_request(16'hFFFF, KIND_W'(i), REF_W'(i), 16'h0000);
      // all loads equal and nonzero: median fallback makes everyone eligible
      queue_request(16'h0001, 4'd9, 16'hAAAA, 16'h8000);
      // one worker just above the rest: fallback excludes it
      queue_request(16'h0000, 4'd10, 16'h5555, 16'hFFFF);
      queue_request(16'h0000, 4'd11, 16'h0000, 16'h0000);
      for (int i = 12; i < 16; i++) begin
         queue_request(WEIGHT_W'($urandom_range(65535)), KIND_W'(i),
                       REF_W'($urandom_range(65535)), RND_W'($urandom_range(65535)));
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         mode = $urandom_range(9);
         case (mode) inside
            [0:3]:   weight = WEIGHT_W'($urandom_range(65535));
            [4:6]:   weight = WEIGHT_W'($urandom_range(255));
            7:       weight = '0;
            8:       weight = '1;
            default: weight = 16'hFF00 | WEIGHT_W'($urandom_range(255));
         endcase
         mode = $urandom_range(9);
         case (mode)
            0:       pick_rnd = '0;
            1:       pick_rnd = '1;
            default: pick_rnd = RND_W'($urandom_range(65535));
         endcase
         queue_request(weight, KIND_W'($urandom_range(15)), REF_W'($urandom_range(65535)),
                       pick_rnd);
      end
      total_requests = pending_req.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < total_requests || expected_pick.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_pick.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
